// File: src/b2ev_pkg.sv
// Package: shared constants, types and functions for the body to earth velocity rotator
package b2ev_pkg;

  localparam int VelW = 24;
  localparam int AngW = 16;
  localparam int CordW = 34;
  localparam int DefaultStages = 16;
  localparam logic signed [CordW-1:0] CordicGain = 34'sd652032874;
  localparam logic signed [VelW-1:0] VelMax = 24'sd8388607;
  localparam logic signed [VelW-1:0] VelMin = -24'sd8388608;

  localparam logic [31:0] AtanTab [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  typedef struct packed {
    logic signed [CordW-1:0] x;
    logic signed [CordW-1:0] y;
    logic [31:0] z;
  } rot_t;

  typedef struct packed {
    logic signed [VelW-1:0] vx;
    logic signed [VelW-1:0] vy;
    logic signed [VelW-1:0] vz;
    logic flip_r;
    logic flip_p;
    logic flip_y;
  } carry_t;

  function automatic logic signed [VelW-1:0] sat24(input logic signed [47:0] v);
    logic signed [VelW-1:0] r;
    if (v > 48'(VelMax)) r = VelMax;
    else if (v < 48'(VelMin)) r = VelMin;
    else r = v[VelW-1:0];
    return r;
  endfunction

endpackage

// File: src/b2ev_cell.sv
// CORDIC cell: one micro-rotation stage for the three angles, with the velocity carried alongside
module b2ev_cell #(
  parameter int IDX = 0
) (
  input  logic clk,
  input  logic en,
  input  b2ev_pkg::rot_t r_in [3],
  input  b2ev_pkg::carry_t c_in,
  output b2ev_pkg::rot_t r_out [3],
  output b2ev_pkg::carry_t c_out
);

  localparam int Sh = (IDX > 31) ? 31 : IDX;
  localparam logic [31:0] Atan = b2ev_pkg::AtanTab[Sh];

  b2ev_pkg::rot_t r_next [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (!r_in[k].z[31]) begin
        r_next[k].x = r_in[k].x - (r_in[k].y >>> Sh);
        r_next[k].y = r_in[k].y + (r_in[k].x >>> Sh);
        r_next[k].z = r_in[k].z - Atan;
      end else begin
        r_next[k].x = r_in[k].x + (r_in[k].y >>> Sh);
        r_next[k].y = r_in[k].y - (r_in[k].x >>> Sh);
        r_next[k].z = r_in[k].z + Atan;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_out <= r_next;
      c_out <= c_in;
    end
  end

endmodule

// File: src/b2ev_rotate.sv
// Rotation pipeline: roll, pitch and yaw products with rounding and saturation
module b2ev_rotate (
  input  logic clk,
  input  logic en,
  input  logic signed [b2ev_pkg::CordW-1:0] cr, sr, cp, sp, cy, sy,
  input  b2ev_pkg::carry_t c_in,
  output logic signed [b2ev_pkg::VelW-1:0] ex,
  output logic signed [b2ev_pkg::VelW-1:0] ey,
  output logic signed [b2ev_pkg::VelW-1:0] eu
);

  localparam int CSW = b2ev_pkg::CordW;
  localparam logic signed [69:0] Half = 70'sd1 <<< 29;

  logic signed [69:0] p1a, p1b, p1c, p1d;
  logic signed [39:0] a2, a3, vx1, vx2;
  logic signed [CSW-1:0] cp1, sp1, cy1, sy1, cp2, sp2, cy2, sy2;
  logic signed [CSW-1:0] cy3, sy3, cy4, sy4;
  logic signed [69:0] p2a, p2b, p2c, p2d;
  logic signed [39:0] b1, b3, a2b, a2c;
  logic signed [69:0] p3a, p3b, p3c, p3d;
  logic signed [47:0] e1, e2, nb3, nb3b;

  function automatic logic signed [39:0] rnd(input logic signed [69:0] s);
    logic signed [69:0] t;
    t = (s + Half) >>> 30;
    return t[39:0];
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      p1a <= 70'(cr) * 70'(c_in.vy);
      p1b <= 70'(-sr) * 70'(c_in.vz);
      p1c <= 70'(sr) * 70'(c_in.vy);
      p1d <= 70'(cr) * 70'(c_in.vz);
      vx1 <= 40'(c_in.vx);
      cp1 <= cp; sp1 <= sp; cy1 <= cy; sy1 <= sy;
      a2 <= rnd(p1a + p1b);
      a3 <= rnd(p1c + p1d);
      vx2 <= vx1;
      cp2 <= cp1; sp2 <= sp1; cy2 <= cy1; sy2 <= sy1;
      p2a <= 70'(cp2) * 70'(vx2);
      p2b <= 70'(sp2) * 70'(a3);
      p2c <= 70'(-sp2) * 70'(vx2);
      p2d <= 70'(cp2) * 70'(a3);
      a2b <= a2; cy3 <= cy2; sy3 <= sy2;
      b1 <= rnd(p2a + p2b);
      b3 <= rnd(p2c + p2d);
      a2c <= a2b; cy4 <= cy3; sy4 <= sy3;
      p3a <= 70'(cy4) * 70'(b1);
      p3b <= 70'(-sy4) * 70'(a2c);
      p3c <= 70'(sy4) * 70'(b1);
      p3d <= 70'(cy4) * 70'(a2c);
      nb3 <= -48'(b3);
      e1 <= 48'(rnd(p3a + p3b));
      e2 <= 48'(rnd(p3c + p3d));
      nb3b <= nb3;
      ex <= b2ev_pkg::sat24(e1);
      ey <= b2ev_pkg::sat24(e2);
      eu <= b2ev_pkg::sat24(nb3b);
    end
  end

  logic unused_ok;
  assign unused_ok = ^{c_in.flip_r, c_in.flip_p, c_in.flip_y};

endmodule

// File: src/body_to_earth_velocity.sv
// Top level: body to earth frame velocity rotation by roll, pitch and yaw
//
// Input channel: body velocity (24-bit, 8 fraction bits) and three 16-bit
// binary angles, valid with stall. Output channel: earth x, earth y and the
// upward rate, valid with stall, one result item for each input item.
// Sines and cosines come from a row of CORDIC_STAGES cells (at most 32), one
// micro-rotation per cell, all three angles side by side; the velocity rides
// along in the same cells. A product pipeline of 7 stages then applies roll,
// pitch and yaw, rounds and saturates.
// Throughput: one item per cycle while the receiver does not stall a waiting result.
// The whole pipeline advances together; when the receiver stalls with a
// result waiting, the pipeline holds and in_stall rises. Reset clears the
// valid bits of every stage; data registers are not reset.
module body_to_earth_velocity #(
  parameter int CORDIC_STAGES = b2ev_pkg::DefaultStages
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic signed [23:0] body_vel_x,
  input  logic signed [23:0] body_vel_y,
  input  logic signed [23:0] body_vel_z,
  input  logic signed [15:0] roll_angle,
  input  logic signed [15:0] pitch_angle,
  input  logic signed [15:0] yaw_angle,
  output logic out_valid,
  input  logic out_stall,
  output logic signed [23:0] earth_vel_x,
  output logic signed [23:0] earth_vel_y,
  output logic signed [23:0] earth_up_rate
);

  localparam int N = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
  localparam int Depth = N + 8;

  logic [Depth-1:0] vld;
  logic en;
  b2ev_pkg::rot_t r [N+1][3];
  b2ev_pkg::carry_t c [N+2];
  logic signed [b2ev_pkg::CordW-1:0] cs [6];
  logic [15:0] ang [3];
  b2ev_pkg::rot_t r0 [3];
  logic [2:0] flip;

  assign en = !(out_valid && out_stall);
  assign in_stall = !en;
  assign out_valid = vld[Depth-1];

  assign ang[0] = roll_angle;
  assign ang[1] = pitch_angle;
  assign ang[2] = yaw_angle;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      flip[k] = ang[k][15] ^ ang[k][14];
      r0[k].x = b2ev_pkg::CordicGain;
      r0[k].y = '0;
      r0[k].z = {ang[k], 16'h0} + (flip[k] ? 32'h8000_0000 : 32'h0);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r[0] <= r0;
      c[0] <= '{vx: body_vel_x, vy: body_vel_y, vz: body_vel_z,
                flip_r: flip[0], flip_p: flip[1], flip_y: flip[2]};
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    b2ev_cell #(.IDX(i)) u_cell (
      .clk(clk), .en(en), .r_in(r[i]), .c_in(c[i]), .r_out(r[i+1]), .c_out(c[i+1])
    );
  end

  always_comb begin
    cs[0] = c[N].flip_r ? -r[N][0].x : r[N][0].x;
    cs[1] = c[N].flip_r ? -r[N][0].y : r[N][0].y;
    cs[2] = c[N].flip_p ? -r[N][1].x : r[N][1].x;
    cs[3] = c[N].flip_p ? -r[N][1].y : r[N][1].y;
    cs[4] = c[N].flip_y ? -r[N][2].x : r[N][2].x;
    cs[5] = c[N].flip_y ? -r[N][2].y : r[N][2].y;
  end

  always_ff @(posedge clk) begin
    if (en) c[N+1] <= c[N];
  end

  b2ev_rotate u_rot (
    .clk(clk), .en(en),
    .cr(cs[0]), .sr(cs[1]), .cp(cs[2]), .sp(cs[3]), .cy(cs[4]), .sy(cs[5]),
    .c_in(c[N]), .ex(earth_vel_x), .ey(earth_vel_y), .eu(earth_up_rate)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[Depth-2:0], in_valid};
    end
  end

  logic unused_c;
  assign unused_c = ^c[N+1];

  assert property (@(posedge clk) disable iff (rst) out_valid && out_stall |=> out_valid);
  assert property (@(posedge clk) disable iff (rst) in_stall == (out_valid && out_stall))
    else $error("stall mismatch");
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(earth_vel_x) && $stable(earth_up_rate))
    else $error("held result changed");

endmodule
